// ===== hdl/kst_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kst_pkg: shared types and constants for the key state tracker
// Opcodes, configuration register indexes and reset values.
// ----------------------------------------------------------------------------
package kst_pkg;

   localparam int OP_W       = 2;
   localparam int KEY_W      = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [OP_W-1:0] {
      OP_EVENT = 2'd0,
      OP_TICK  = 2'd1,
      OP_POLL  = 2'd2
   } op_type;

   localparam logic [CSR_IDX_W-1:0] CSR_LONG_THRESHOLD  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REPEAT_INTERVAL = 2'd1;

   localparam logic [CSR_DATA_W-1:0] LONG_THRESHOLD_RST  = 32'd1000;
   localparam logic [CSR_DATA_W-1:0] REPEAT_INTERVAL_RST = 32'd100;

endpackage

// ===== hdl/kst_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kst_table: per-key state memory
// One read and one write port, registered read data, forwarding of the most
// recent write, and a zeroing sweep over every entry after reset.
// ----------------------------------------------------------------------------
module kst_table #(
   parameter int NUM_KEYS = 256,
   parameter int ENTRY_W  = 67,
   parameter int ADDR_W   = $clog2(NUM_KEYS)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               rd_en,
   input  logic [ADDR_W-1:0]  rd_addr,
   output logic [ENTRY_W-1:0] rd_data,
   input  logic               wr_en,
   input  logic [ADDR_W-1:0]  wr_addr,
   input  logic [ENTRY_W-1:0] wr_data,
   output logic               clearing
);

   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NUM_KEYS - 1);

   logic [ENTRY_W-1:0] mem [NUM_KEYS];

   logic [ENTRY_W-1:0] ram_q_ff;
   logic [ADDR_W-1:0]  rd_addr_ff;
   logic               clr_active_ff;
   logic [ADDR_W-1:0]  clr_addr_ff;
   logic               byp_valid_ff;
   logic [ADDR_W-1:0]  byp_addr_ff;
   logic [ENTRY_W-1:0] byp_data_ff;

   // storage: sweep writes zero, otherwise normal write port
   always_ff @(posedge clock) begin
      if (clr_active_ff) begin
         mem[clr_addr_ff] <= '0;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         ram_q_ff   <= mem[rd_addr];
         rd_addr_ff <= rd_addr;
      end
      if (wr_en) begin
         byp_addr_ff <= wr_addr;
         byp_data_ff <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
         byp_valid_ff  <= 1'b0;
      end else begin
         if (clr_active_ff) begin
            if (clr_addr_ff == LAST_ADDR) begin
               clr_active_ff <= 1'b0;
            end
            clr_addr_ff <= clr_addr_ff + ADDR_W'(1);
         end
         if (wr_en) begin
            byp_valid_ff <= 1'b1;
         end
      end
   end

   // last write to the same key is newest (covers write/read on the same edge)
   assign rd_data  = (byp_valid_ff && (byp_addr_ff == rd_addr_ff)) ? byp_data_ff : ram_q_ff;
   assign clearing = clr_active_ff;

endmodule

// ===== hdl/key_state_tracker_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_state_tracker_core: per-key press/release tracker with long press repeat
// Event, tick and poll words update a key table and a millisecond counter.
// ----------------------------------------------------------------------------
// Takes one request word per cycle while req_stall is low and returns a poll's
// response through the input register with table read, then the response
// register. Events and ticks produce no response. Throughput is one word per
// clock when nothing stalls, set by the read-modify-write of the key table;
// a stall on the response side holds a poll in the working stage and
// back-pressures the request side. After reset the key table is zeroed one
// entry per cycle, and req_stall stays high until that sweep is done.
// Configuration writes are taken at any time (csr_ready is always high) and
// are meant to be issued while the block is idle.
// ----------------------------------------------------------------------------
module key_state_tracker_core #(
   parameter int NUM_KEYS  = 256,
   parameter int TIME_BITS = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [kst_pkg::OP_W-1:0]        req_opcode,
   input  logic [kst_pkg::KEY_W-1:0]       req_key_index,
   input  logic                            req_now_up,
   input  logic                            req_prior_down,
   // response channel
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_key_is_down,
   output logic                            rsp_pressed_seen,
   output logic                            rsp_released_seen,
   output logic                            rsp_long_press_due,
   // configuration write channel
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [kst_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [kst_pkg::CSR_DATA_W-1:0]  csr_data
);

   import kst_pkg::*;

   localparam int KEY_AW  = $clog2(NUM_KEYS);
   localparam int EXT_W   = (KEY_AW > KEY_W) ? KEY_AW : KEY_W;
   localparam int CMP_W   = (TIME_BITS > CSR_DATA_W) ? TIME_BITS : CSR_DATA_W;
   // entry layout: down | pressed | released | press time | last report time
   localparam int ENTRY_W = 3 + 2 * TIME_BITS;
   localparam int DOWN_B  = ENTRY_W - 1;
   localparam int PRS_B   = ENTRY_W - 2;
   localparam int REL_B   = ENTRY_W - 3;

   // ---------------------------------------------------------------------
   // configuration registers
   // ---------------------------------------------------------------------
   logic [CSR_DATA_W-1:0] long_thr_ff;
   logic [CSR_DATA_W-1:0] rpt_int_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         long_thr_ff <= LONG_THRESHOLD_RST;
         rpt_int_ff  <= REPEAT_INTERVAL_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_LONG_THRESHOLD:  long_thr_ff <= csr_data;
            CSR_REPEAT_INTERVAL: rpt_int_ff  <= csr_data;
            default: ;  // unmapped index, dropped
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // request acceptance and working stage
   // ---------------------------------------------------------------------
   logic                 clearing;
   logic                 req_accept;
   logic                 s1_valid_ff;
   logic                 s1_valid_in;
   op_type               s1_op_ff;
   logic [KEY_AW-1:0]    s1_addr_ff;
   logic                 s1_key_ok_ff;
   logic                 s1_now_up_ff;
   logic                 s1_prior_ff;
   logic                 s1_adv;
   logic                 rsp_valid_ff;

   logic [EXT_W-1:0]     key_ext;
   logic [KEY_AW-1:0]    req_addr;
   logic                 req_key_ok;

   assign key_ext    = EXT_W'(req_key_index);
   assign req_addr   = key_ext[KEY_AW-1:0];
   assign req_key_ok = (32'(req_key_index) < NUM_KEYS);

   // a poll waits in stage 1 while the response register is stalled
   assign s1_adv     = s1_valid_ff &&
                       !((s1_op_ff == OP_POLL) && rsp_valid_ff && rsp_stall);
   assign req_stall  = clearing || (s1_valid_ff && !s1_adv);
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_op_ff     <= op_type'(req_opcode);
         s1_addr_ff   <= req_addr;
         s1_key_ok_ff <= req_key_ok;
         s1_now_up_ff <= req_now_up;
         s1_prior_ff  <= req_prior_down;
      end
   end

   // ---------------------------------------------------------------------
   // key table
   // ---------------------------------------------------------------------
   logic [ENTRY_W-1:0] tbl_rd_data;
   logic [ENTRY_W-1:0] tbl_wr_data;
   logic               tbl_wr_en;

   kst_table #(
      .NUM_KEYS (NUM_KEYS),
      .ENTRY_W  (ENTRY_W),
      .ADDR_W   (KEY_AW)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (req_accept),
      .rd_addr  (req_addr),
      .rd_data  (tbl_rd_data),
      .wr_en    (tbl_wr_en),
      .wr_addr  (s1_addr_ff),
      .wr_data  (tbl_wr_data),
      .clearing (clearing)
   );

   // ---------------------------------------------------------------------
   // millisecond counter, advanced in order with the other words
   // ---------------------------------------------------------------------
   logic [TIME_BITS-1:0] ms_cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ms_cnt_ff <= '0;
      end else if (s1_adv && (s1_op_ff == OP_TICK)) begin
         ms_cnt_ff <= ms_cnt_ff + TIME_BITS'(1);
      end
   end

   // ---------------------------------------------------------------------
   // entry update and poll result
   // ---------------------------------------------------------------------
   logic                 rd_down;
   logic                 rd_pressed;
   logic                 rd_released;
   logic [TIME_BITS-1:0] rd_press_t;
   logic [TIME_BITS-1:0] rd_last_t;
   logic [TIME_BITS-1:0] held_t;
   logic [TIME_BITS-1:0] since_rpt_t;
   logic                 long_due;

   logic                 nx_down;
   logic                 nx_pressed;
   logic                 nx_released;
   logic [TIME_BITS-1:0] nx_press_t;
   logic [TIME_BITS-1:0] nx_last_t;
   logic                 upd_req;
   logic                 res_down;
   logic                 res_pressed;
   logic                 res_released;
   logic                 res_due;

   assign rd_down     = tbl_rd_data[DOWN_B];
   assign rd_pressed  = tbl_rd_data[PRS_B];
   assign rd_released = tbl_rd_data[REL_B];
   assign rd_press_t  = tbl_rd_data[2*TIME_BITS-1:TIME_BITS];
   assign rd_last_t   = tbl_rd_data[TIME_BITS-1:0];

   // differences wrap at the counter width
   assign held_t      = ms_cnt_ff - rd_press_t;
   assign since_rpt_t = ms_cnt_ff - rd_last_t;
   assign long_due    = rd_down &&
                        (CMP_W'(held_t) > CMP_W'(long_thr_ff)) &&
                        (CMP_W'(since_rpt_t) > CMP_W'(rpt_int_ff));

   always_comb begin
      nx_down      = rd_down;
      nx_pressed   = rd_pressed;
      nx_released  = rd_released;
      nx_press_t   = rd_press_t;
      nx_last_t    = rd_last_t;
      upd_req      = 1'b0;
      res_down     = 1'b0;
      res_pressed  = 1'b0;
      res_released = 1'b0;
      res_due      = 1'b0;
      case (s1_op_ff)
         OP_EVENT: begin
            if (s1_key_ok_ff) begin
               if (!s1_now_up_ff && !s1_prior_ff) begin
                  // fresh press, restamps even if already down
                  nx_down    = 1'b1;
                  nx_pressed = 1'b1;
                  nx_press_t = ms_cnt_ff;
                  upd_req    = 1'b1;
               end else if (s1_now_up_ff && s1_prior_ff) begin
                  nx_down     = 1'b0;
                  nx_released = 1'b1;
                  upd_req     = 1'b1;
               end
            end
         end
         OP_POLL: begin
            // out-of-range key: all-zero result, no update
            if (s1_key_ok_ff) begin
               res_down     = rd_down;
               res_pressed  = rd_pressed;
               res_released = rd_released;
               res_due      = long_due;
               nx_pressed   = 1'b0;
               nx_released  = 1'b0;
               if (!rd_down) begin
                  nx_last_t = '0;
               end else if (long_due) begin
                  nx_last_t = ms_cnt_ff;
               end
               upd_req = 1'b1;
            end
         end
         default: ;  // tick handled by the counter, unused code ignored
      endcase
   end

   assign tbl_wr_en   = s1_adv && upd_req;
   assign tbl_wr_data = {nx_down, nx_pressed, nx_released, nx_press_t, nx_last_t};

   // ---------------------------------------------------------------------
   // response register
   // ---------------------------------------------------------------------
   logic rsp_valid_in;
   logic rsp_load;
   logic rsp_down_ff;
   logic rsp_pressed_ff;
   logic rsp_released_ff;
   logic rsp_due_ff;

   assign rsp_load = s1_adv && (s1_op_ff == OP_POLL);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_down_ff     <= res_down;
         rsp_pressed_ff  <= res_pressed;
         rsp_released_ff <= res_released;
         rsp_due_ff      <= res_due;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_key_is_down    = rsp_down_ff;
   assign rsp_pressed_seen   = rsp_pressed_ff;
   assign rsp_released_seen  = rsp_released_ff;
   assign rsp_long_press_due = rsp_due_ff;

endmodule

// ===== hdl/kst_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kst_checker: port-level checks for the key state tracker
// Watches the request and response channels of the top level.
// ----------------------------------------------------------------------------
module kst_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_stall,
   input logic [kst_pkg::OP_W-1:0]  req_opcode,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input logic                      rsp_key_is_down,
   input logic                      rsp_pressed_seen,
   input logic                      rsp_released_seen,
   input logic                      rsp_long_press_due
);

   import kst_pkg::*;

   // a stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid &&
         $stable({rsp_key_is_down, rsp_pressed_seen, rsp_released_seen, rsp_long_press_due}))
      else $error("response word changed while stalled");

   // table sweep after reset blocks requests
   a_clear_stall: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("request taken during table sweep");

   // a long press is only reported for a held key
   a_due_down: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_long_press_due |-> rsp_key_is_down)
      else $error("long press reported for a key that is up");

   // a fresh response word comes from an accepted poll request
   a_rsp_from_poll: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |->
         $past(req_valid && !req_stall && (req_opcode == OP_POLL), 2))
      else $error("response without a poll");

endmodule

bind key_state_tracker_core kst_checker u_kst_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .req_opcode         (req_opcode),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_key_is_down    (rsp_key_is_down),
   .rsp_pressed_seen   (rsp_pressed_seen),
   .rsp_released_seen  (rsp_released_seen),
   .rsp_long_press_due (rsp_long_press_due)
);
